### rtl/fsn_pkg.sv
`timescale 1ns / 1ps
// fsn_pkg: constants, codes, state and command types of the fractal noise block
// no dependencies; imported by fsn_ctrl, fsn_dp and fractal_simplex_noise_2d
package fsn_pkg;

    localparam int TABLE_SIZE  = 256;
    localparam int TAB_AW      = 8;
    localparam int MAX_OCTAVES = 16;
    localparam int DIV_BITS    = 39;

    localparam logic [31:0] SKEW_Q32   = 32'd1572067135;
    localparam logic [31:0] UNSKEW_Q32 = 32'd907633384;
    localparam logic [31:0] DIAG_Q32   = 32'd3036441878;

    localparam logic [33:0] ONE_QF  = 34'd65536;
    localparam logic [33:0] G2_QF   = 34'((64'(UNSKEW_Q32) + 64'd32768) >> 16);
    localparam logic [33:0] DIAG_QF = 34'((64'(DIAG_Q32) + 64'd32768) >> 16);

    localparam logic [25:0] HALF_QF   = 26'd32768;
    localparam logic [31:0] FREQ_INIT = 32'd65536;
    localparam logic [15:0] AMP_INIT  = 16'd32768;

    localparam logic signed [19:0] CRN_ONE  = 20'sd65536;
    localparam logic signed [19:0] CRN_G2   = 20'(G2_QF);
    localparam logic signed [19:0] CRN_G2X2 = 20'(G2_QF << 1);

    localparam logic [5:0] DIV_LAST = 6'(DIV_BITS - 1);

    // configuration register indexes
    localparam logic [1:0] CFG_OCTAVES = 2'd0;
    localparam logic [1:0] CFG_LACUN   = 2'd1;
    localparam logic [1:0] CFG_GAIN    = 2'd2;

    // item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_EVAL = 1'b1;

    // simplex corners
    localparam logic [1:0] CRN_FIRST = 2'd0;
    localparam logic [1:0] CRN_MID   = 2'd1;
    localparam logic [1:0] CRN_LAST  = 2'd2;

    // table lookup steps
    localparam logic [2:0] RD_PJ0 = 3'd0;
    localparam logic [2:0] RD_PJ1 = 3'd1;
    localparam logic [2:0] RD_PJ2 = 3'd2;
    localparam logic [2:0] RD_H0  = 3'd3;
    localparam logic [2:0] RD_H1  = 3'd4;
    localparam logic [2:0] RD_H2  = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_WB, ST_RD, ST_CAP, ST_DVI, ST_DIV, ST_OUT
    } t_state;

    typedef enum logic [3:0] {
        OP_SCX, OP_SCY, OP_SKEW, OP_UNSK, OP_CXX, OP_CYY, OP_TSQ1, OP_TSQ2,
        OP_DOT, OP_CON, OP_AMP, OP_GAIN, OP_LAC
    } t_op;

    typedef struct packed {
        logic       init;
        logic       wb;
        t_op        op;
        logic [1:0] crn;
        logic [2:0] rd_sel;
        logic       cap;
        logic       div_init;
        logic       div_step;
        logic       emit;
    } t_cmd;

    typedef struct packed {
        logic       t_neg;
        logic [3:0] oct_last;
    } t_sts;

endpackage

### rtl/fsn_ram.sv
`timescale 1ns / 1ps
// fsn_ram: generic single write port, single read port ram with registered read
// no dependencies
module fsn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/fsn_ctrl.sv
`timescale 1ns / 1ps
// fsn_ctrl: sequencer of the fractal noise block, octave, corner, lookup and divide steps
// depends on fsn_pkg
module fsn_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_kind,
    input  fsn_pkg::t_sts i_sts,
    output fsn_pkg::t_cmd o_cmd,
    output logic          o_busy
);
    import fsn_pkg::*;

    t_state     r_state, n_state;
    t_op        r_op, n_op;
    logic [1:0] r_crn, n_crn;
    logic [2:0] r_rd, n_rd;
    logic [3:0] r_oct, n_oct;
    logic [5:0] r_div, n_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= OP_SCX;
            r_crn   <= CRN_FIRST;
            r_rd    <= RD_PJ0;
            r_oct   <= '0;
            r_div   <= '0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_crn   <= n_crn;
            r_rd    <= n_rd;
            r_oct   <= n_oct;
            r_div   <= n_div;
        end
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_crn   = r_crn;
        n_rd    = r_rd;
        n_oct   = r_oct;
        n_div   = r_div;
        case (r_state)
            ST_IDLE: begin
                if (i_start && i_kind == KIND_EVAL) begin
                    n_state = ST_MUL;
                    n_op    = OP_SCX;
                    n_oct   = '0;
                end
            end
            ST_MUL: begin
                // corner outside radius skips its remaining products
                if (r_op == OP_TSQ1 && i_sts.t_neg) begin
                    if (r_crn == CRN_LAST) begin
                        n_op = OP_AMP;
                    end else begin
                        n_crn = r_crn + 2'd1;
                        n_op  = OP_CXX;
                    end
                end else begin
                    n_state = ST_WB;
                end
            end
            ST_WB: begin
                n_state = ST_MUL;
                case (r_op)
                    OP_SCX:  n_op = OP_SCY;
                    OP_SCY:  n_op = OP_SKEW;
                    OP_SKEW: n_op = OP_UNSK;
                    OP_UNSK: begin
                        n_state = ST_RD;
                        n_rd    = RD_PJ0;
                    end
                    OP_CXX:  n_op = OP_CYY;
                    OP_CYY:  n_op = OP_TSQ1;
                    OP_TSQ1: n_op = OP_TSQ2;
                    OP_TSQ2: n_op = OP_DOT;
                    OP_DOT:  n_op = OP_CON;
                    OP_CON: begin
                        if (r_crn == CRN_LAST) begin
                            n_op = OP_AMP;
                        end else begin
                            n_crn = r_crn + 2'd1;
                            n_op  = OP_CXX;
                        end
                    end
                    OP_AMP:  n_op = OP_GAIN;
                    OP_GAIN: n_op = OP_LAC;
                    OP_LAC: begin
                        if (r_oct == i_sts.oct_last) begin
                            n_state = ST_DVI;
                        end else begin
                            n_oct = r_oct + 4'd1;
                            n_op  = OP_SCX;
                        end
                    end
                    default: n_state = ST_IDLE;
                endcase
            end
            ST_RD: n_state = ST_CAP;
            ST_CAP: begin
                if (r_rd == RD_H2) begin
                    n_state = ST_MUL;
                    n_op    = OP_CXX;
                    n_crn   = CRN_FIRST;
                end else begin
                    n_state = ST_RD;
                    n_rd    = r_rd + 3'd1;
                end
            end
            ST_DVI: begin
                n_state = ST_DIV;
                n_div   = '0;
            end
            ST_DIV: begin
                if (r_div == DIV_LAST) begin
                    n_state = ST_OUT;
                end else begin
                    n_div = r_div + 6'd1;
                end
            end
            ST_OUT:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.op       = r_op;
        o_cmd.crn      = r_crn;
        o_cmd.rd_sel   = r_rd;
        o_cmd.init     = (r_state == ST_IDLE) && i_start && (i_kind == KIND_EVAL);
        o_cmd.wb       = (r_state == ST_WB);
        o_cmd.cap      = (r_state == ST_CAP);
        o_cmd.div_init = (r_state == ST_DVI);
        o_cmd.div_step = (r_state == ST_DIV);
        o_cmd.emit     = (r_state == ST_OUT);
        o_busy         = (r_state != ST_IDLE);
    end

endmodule

### rtl/fsn_dp.sv
`timescale 1ns / 1ps
// fsn_dp: datapath of the fractal noise block, shared multiplier, corner math, divider
// depends on fsn_pkg; reads the permutation table through fsn_ram
module fsn_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [1:0]                 i_cfg_index,
    input  logic [15:0]                i_cfg_data,
    input  logic signed [31:0]         i_coord_x,
    input  logic signed [31:0]         i_coord_y,
    input  fsn_pkg::t_cmd              i_cmd,
    output fsn_pkg::t_sts              o_sts,
    output logic [fsn_pkg::TAB_AW-1:0] o_rd_addr,
    input  logic [7:0]                 i_rd_data,
    output logic                       o_valid,
    output logic signed [15:0]         o_noise_value
);
    import fsn_pkg::*;

    logic [4:0]         r_octaves;
    logic [15:0]        r_lacun;
    logic [15:0]        r_gain;
    logic               r_valid;
    logic [15:0]        r_out;

    logic signed [31:0] r_cx, r_cy;
    logic [31:0]        r_freq;
    logic [15:0]        r_amp;
    logic signed [24:0] r_sum;
    logic [19:0]        r_total;
    logic signed [67:0] r_prod;
    logic signed [31:0] r_px, r_py;
    logic signed [17:0] r_ci, r_cj;
    logic signed [19:0] r_x0, r_y0;
    logic [7:0]         r_lk [6];
    logic [23:0]        r_a;
    logic signed [25:0] r_t;
    logic signed [21:0] r_dot;
    logic signed [23:0] r_n;
    logic [20:0]        r_rem;
    logic [DIV_BITS-1:0] r_quo;
    logic               r_neg;

    logic               w_i1;
    logic signed [19:0] w_cx, w_cy;
    logic [2:0]         w_h;
    logic signed [20:0] w_cx21, w_cy21, w_tx, w_ty, w_base, w_ax, w_combo;
    logic signed [33:0] w_op_a, w_op_b;
    logic signed [31:0] w_s;
    logic signed [33:0] w_sx, w_sy;
    logic signed [35:0] w_x0, w_y0;
    logic [25:0]        w_t_new;
    logic signed [23:0] w_c, w_c70;
    logic [24:0]        w_mag;
    logic [20:0]        w_rs;
    logic [21:0]        w_df;
    logic [15:0]        w_sat;
    logic [3:0]         w_oct_last;

    // configuration and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_octaves <= 5'd4;
            r_lacun   <= 16'd8192;
            r_gain    <= 16'd32768;
            r_valid   <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_OCTAVES: r_octaves <= i_cfg_data[4:0];
                    CFG_LACUN:   r_lacun   <= i_cfg_data;
                    CFG_GAIN:    r_gain    <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        if (r_octaves == 5'd0) begin
            w_oct_last = 4'd0;
        end else if (r_octaves > 5'(MAX_OCTAVES)) begin
            w_oct_last = 4'(MAX_OCTAVES - 1);
        end else begin
            w_oct_last = 4'(r_octaves - 5'd1);
        end
        o_sts.oct_last = w_oct_last;
        o_sts.t_neg    = r_t[25];
    end

    // corner offsets and gradient projection
    assign w_i1 = (r_x0 > r_y0);

    always_comb begin
        w_cx = r_x0;
        w_cy = r_y0;
        w_h  = r_lk[3][2:0];
        case (i_cmd.crn)
            CRN_FIRST: begin
                w_cx = r_x0;
                w_cy = r_y0;
                w_h  = r_lk[3][2:0];
            end
            CRN_MID: begin
                w_cx = r_x0 - (w_i1 ? CRN_ONE : 20'sd0) + CRN_G2;
                w_cy = r_y0 - (w_i1 ? 20'sd0 : CRN_ONE) + CRN_G2;
                w_h  = r_lk[4][2:0];
            end
            CRN_LAST: begin
                w_cx = r_x0 - CRN_ONE + CRN_G2X2;
                w_cy = r_y0 - CRN_ONE + CRN_G2X2;
                w_h  = r_lk[5][2:0];
            end
            default: ;
        endcase
        w_cx21  = {w_cx[19], w_cx};
        w_cy21  = {w_cy[19], w_cy};
        w_tx    = w_h[0] ? -w_cx21 : w_cx21;
        w_ty    = w_h[1] ? -w_cy21 : w_cy21;
        w_base  = w_h[1] ? w_cy21 : w_cx21;
        w_ax    = w_h[0] ? -w_base : w_base;
        w_combo = w_h[2] ? (w_tx + w_ty) : w_ax;
    end

    // operand select of the shared multiplier
    always_comb begin
        w_op_a = '0;
        w_op_b = '0;
        case (i_cmd.op)
            OP_SCX: begin
                w_op_a = {{2{r_cx[31]}}, r_cx};
                w_op_b = {2'b00, r_freq};
            end
            OP_SCY: begin
                w_op_a = {{2{r_cy[31]}}, r_cy};
                w_op_b = {2'b00, r_freq};
            end
            OP_SKEW: begin
                w_op_a = {{2{r_px[31]}}, r_px} + {{2{r_py[31]}}, r_py};
                w_op_b = {2'b00, SKEW_Q32};
            end
            OP_UNSK: begin
                w_op_a = {{16{r_ci[17]}}, r_ci} + {{16{r_cj[17]}}, r_cj};
                w_op_b = G2_QF;
            end
            OP_CXX: begin
                w_op_a = {{14{w_cx[19]}}, w_cx};
                w_op_b = {{14{w_cx[19]}}, w_cx};
            end
            OP_CYY: begin
                w_op_a = {{14{w_cy[19]}}, w_cy};
                w_op_b = {{14{w_cy[19]}}, w_cy};
            end
            OP_TSQ1, OP_TSQ2: begin
                w_op_a = {{8{r_t[25]}}, r_t};
                w_op_b = {{8{r_t[25]}}, r_t};
            end
            OP_DOT: begin
                w_op_a = {{13{w_combo[20]}}, w_combo};
                w_op_b = w_h[2] ? DIAG_QF : ONE_QF;
            end
            OP_CON: begin
                w_op_a = {{8{r_t[25]}}, r_t};
                w_op_b = {{12{r_dot[21]}}, r_dot};
            end
            OP_AMP: begin
                w_op_a = {18'd0, r_amp};
                w_op_b = {{10{r_n[23]}}, r_n};
            end
            OP_GAIN: begin
                w_op_a = {18'd0, r_amp};
                w_op_b = {18'd0, r_gain};
            end
            OP_LAC: begin
                w_op_a = {2'b00, r_freq};
                w_op_b = {18'd0, r_lacun};
            end
            default: ;
        endcase
    end

    // writeback, divide and saturation helpers
    always_comb begin
        w_s     = r_prod[63:32];
        w_sx    = {{2{r_px[31]}}, r_px} + {{2{w_s[31]}}, w_s};
        w_sy    = {{2{r_py[31]}}, r_py} + {{2{w_s[31]}}, w_s};
        w_x0    = {{4{r_px[31]}}, r_px} - {{2{r_ci[17]}}, r_ci, 16'd0} + r_prod[35:0];
        w_y0    = {{4{r_py[31]}}, r_py} - {{2{r_cj[17]}}, r_cj, 16'd0} + r_prod[35:0];
        w_t_new = HALF_QF - {2'b00, r_a} - {2'b00, r_prod[39:16]};
        w_c     = {{6{r_prod[33]}}, r_prod[33:16]};
        w_c70   = (w_c <<< 6) + (w_c <<< 2) + (w_c <<< 1);
        w_mag   = r_sum[24] ? 25'(-r_sum) : 25'(r_sum);
        w_rs    = {r_rem[19:0], r_quo[DIV_BITS-1]};
        w_df    = {1'b0, w_rs} - {2'b00, r_total};
        if (r_neg) begin
            w_sat = (r_quo > 39'd32768) ? 16'h8000 : 16'(-r_quo);
        end else begin
            w_sat = (r_quo > 39'd32767) ? 16'h7fff : r_quo[15:0];
        end
    end

    always_comb begin
        o_rd_addr = r_cj[7:0];
        case (i_cmd.rd_sel)
            RD_PJ0: o_rd_addr = r_cj[7:0];
            RD_PJ1: o_rd_addr = r_cj[7:0] + {7'd0, ~w_i1};
            RD_PJ2: o_rd_addr = r_cj[7:0] + 8'd1;
            RD_H0:  o_rd_addr = r_ci[7:0] + r_lk[0];
            RD_H1:  o_rd_addr = r_ci[7:0] + {7'd0, w_i1} + r_lk[1];
            RD_H2:  o_rd_addr = r_ci[7:0] + 8'd1 + r_lk[2];
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_op_a * w_op_b;
        if (i_cmd.init) begin
            r_cx    <= i_coord_x;
            r_cy    <= i_coord_y;
            r_freq  <= FREQ_INIT;
            r_amp   <= AMP_INIT;
            r_sum   <= '0;
            r_total <= '0;
        end
        if (i_cmd.cap) begin
            r_lk[i_cmd.rd_sel] <= i_rd_data;
        end
        if (i_cmd.wb) begin
            case (i_cmd.op)
                OP_SCX: r_px <= r_prod[47:16];
                OP_SCY: r_py <= r_prod[47:16];
                OP_SKEW: begin
                    r_ci <= w_sx[33:16];
                    r_cj <= w_sy[33:16];
                    r_n  <= '0;
                end
                OP_UNSK: begin
                    r_x0 <= w_x0[19:0];
                    r_y0 <= w_y0[19:0];
                end
                OP_CXX:           r_a   <= r_prod[39:16];
                OP_CYY:           r_t   <= w_t_new;
                OP_TSQ1, OP_TSQ2: r_t   <= r_prod[41:16];
                OP_DOT:           r_dot <= r_prod[37:16];
                OP_CON:           r_n   <= r_n + w_c70;
                OP_AMP: begin
                    r_sum   <= r_sum + r_prod[40:16];
                    r_total <= r_total + {4'd0, r_amp};
                end
                OP_GAIN: r_amp <= r_prod[31:16];
                OP_LAC:  r_freq <= (|r_prod[47:44]) ? 32'hffff_ffff : r_prod[43:12];
                default: ;
            endcase
        end
        if (i_cmd.div_init) begin
            r_neg <= r_sum[24];
            r_quo <= {w_mag, 14'd0};
            r_rem <= '0;
        end
        if (i_cmd.div_step) begin
            if (!w_df[21]) begin
                r_rem <= w_df[20:0];
                r_quo <= {r_quo[DIV_BITS-2:0], 1'b1};
            end else begin
                r_rem <= w_rs;
                r_quo <= {r_quo[DIV_BITS-2:0], 1'b0};
            end
        end
        if (i_cmd.emit) begin
            r_out <= w_sat;
        end
    end

    assign o_valid       = r_valid;
    assign o_noise_value = r_out;

endmodule

### rtl/fractal_simplex_noise_2d.sv
`timescale 1ns / 1ps
// fractal_simplex_noise_2d: top level, fractal sum of 2d simplex noise at one point
// depends on fsn_pkg, fsn_ram, fsn_ctrl, fsn_dp
//
// A load item (kind 0) writes one permutation entry in the cycle it is accepted and
// leaves busy low. An evaluate item (kind 1) raises busy while it runs: per octave
// four setup products, six table lookups, three corners of six products each (a
// corner outside the radius skips its remaining products) and three weighting
// products, then a divide setup step, a bit-serial divide and an output step.
// Its run time is set by the single shared multiplier, one product at a time, and
// the single read port of the table. The result appears on o_noise_value for
// exactly one cycle with o_valid high, the first cycle in which busy is low again;
// the receiver cannot stall it. Table entries must be loaded before they are read.
module fractal_simplex_noise_2d (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_kind,
    input  logic [7:0]         i_table_index,
    input  logic [7:0]         i_table_value,
    input  logic signed [31:0] i_coord_x,
    input  logic signed [31:0] i_coord_y,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output logic               o_valid,
    output logic signed [15:0] o_noise_value
);
    import fsn_pkg::*;

    t_cmd              w_cmd;
    t_sts              w_sts;
    logic [TAB_AW-1:0] w_rd_addr;
    logic [7:0]        w_rd_data;
    logic              w_load;

    assign w_load = start && !busy && (i_kind == KIND_LOAD);

    fsn_ram #(
        .WIDTH(8),
        .DEPTH(TABLE_SIZE)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (i_table_index),
        .i_wdata (i_table_value),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rd_data)
    );

    fsn_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_kind  (i_kind),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    fsn_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_rd_addr     (w_rd_addr),
        .i_rd_data     (w_rd_data),
        .o_valid       (o_valid),
        .o_noise_value (o_noise_value)
    );

endmodule

### test/fractal_simplex_noise_2d_tb.sv
`timescale 1ns / 1ps
// fractal_simplex_noise_2d_tb: self-checking bench for the fractal simplex noise block
// loads the permutation table, runs directed and random items through several settings
// depends on fsn_pkg and fractal_simplex_noise_2d
module fractal_simplex_noise_2d_tb;
    import fsn_pkg::*;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               i_kind = KIND_LOAD;
    logic [7:0]         i_table_index = '0;
    logic [7:0]         i_table_value = '0;
    logic signed [31:0] i_coord_x = '0;
    logic signed [31:0] i_coord_y = '0;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_index = CFG_OCTAVES;
    logic [15:0]        i_cfg_data = '0;
    logic               o_valid;
    logic signed [15:0] o_noise_value;

    fractal_simplex_noise_2d i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    typedef struct {
        logic               kind;
        logic [7:0]         idx;
        logic [7:0]         val;
        logic signed [31:0] x;
        logic signed [31:0] y;
    } t_row;

    // predictor state
    logic [7:0]  perm_copy [256];
    logic [4:0]  octaves_reg = 5'd4;
    logic [15:0] lacun_reg = 16'd8192;
    logic [15:0] gain_reg = 16'd32768;

    logic signed [15:0] noise_queue [$];
    int mismatches = 0;
    int evals_done = 0;
    int loads_done = 0;
    bit allow_idle = 1'b1;

    localparam longint G2C   = (longint'(UNSKEW_Q32) + 32768) >>> 16;
    localparam longint DIAGC = (longint'(DIAG_Q32) + 32768) >>> 16;
    localparam longint ONE   = 65536;

    function automatic longint corner_gain(longint cx, longint cy, logic [7:0] h);
        longint t, gx, gy, dp;
        t = 32768 - ((cx * cx) >>> 16) - ((cy * cy) >>> 16);
        if (t < 0) return 0;
        t = (t * t) >>> 16;
        t = (t * t) >>> 16;
        case (h[2:0])
            3'd0: begin gx = ONE; gy = 0; end
            3'd1: begin gx = -ONE; gy = 0; end
            3'd2: begin gx = 0; gy = ONE; end
            3'd3: begin gx = 0; gy = -ONE; end
            3'd4: begin gx = DIAGC; gy = DIAGC; end
            3'd5: begin gx = -DIAGC; gy = DIAGC; end
            3'd6: begin gx = DIAGC; gy = -DIAGC; end
            default: begin gx = -DIAGC; gy = -DIAGC; end
        endcase
        dp = (gx * cx + gy * cy) >>> 16;
        return (t * dp) >>> 16;
    endfunction

    function automatic longint octave_noise(longint px, longint py);
        longint s, ci, cj, t, x0, y0, x1, y1, x2, y2, i1, j1;
        logic [7:0] ii, jj, h0, h1, h2;
        s  = ((px + py) * longint'(SKEW_Q32)) >>> 32;
        ci = (px + s) >>> 16;
        cj = (py + s) >>> 16;
        t  = (ci + cj) * G2C;
        x0 = px - (ci * ONE - t);
        y0 = py - (cj * ONE - t);
        i1 = (x0 > y0) ? 1 : 0;
        j1 = 1 - i1;
        x1 = x0 - i1 * ONE + G2C;
        y1 = y0 - j1 * ONE + G2C;
        x2 = x0 - ONE + 2 * G2C;
        y2 = y0 - ONE + 2 * G2C;
        ii = ci[7:0];
        jj = cj[7:0];
        h0 = perm_copy[8'(ii + perm_copy[jj])];
        h1 = perm_copy[8'(ii + 8'(i1) + perm_copy[8'(jj + 8'(j1))])];
        h2 = perm_copy[8'(ii + 8'd1 + perm_copy[8'(jj + 8'd1)])];
        return 70 * (corner_gain(x0, y0, h0) + corner_gain(x1, y1, h1)
                     + corner_gain(x2, y2, h2));
    endfunction

    function automatic longint scale_coord(logic signed [31:0] c, logic [63:0] freq);
        logic [63:0] prod;
        prod = 64'(longint'(c)) * freq;
        return longint'($signed(prod[47:16]));
    endfunction

    function automatic logic signed [15:0] fbm_noise(logic signed [31:0] x,
                                                     logic signed [31:0] y);
        logic [63:0] freq, amp;
        longint sum, total, r, nv;
        int n;
        freq = 64'd65536;
        amp = 64'd32768;
        sum = 0;
        total = 0;
        n = (octaves_reg == 0) ? 1 : (octaves_reg > MAX_OCTAVES) ? MAX_OCTAVES
                                                                  : int'(octaves_reg);
        for (int k = 0; k < n; k++) begin
            nv = octave_noise(scale_coord(x, freq), scale_coord(y, freq));
            sum += (longint'(amp) * nv) >>> 16;
            total += longint'(amp);
            amp = (amp * gain_reg) >> 16;
            freq = (freq * lacun_reg) >> 12;
            if (freq > 64'hFFFF_FFFF) freq = 64'hFFFF_FFFF;
        end
        r = (sum * 16384) / total;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return 16'(r);
    endfunction

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (noise_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %0d", o_noise_value);
            end else begin
                if (o_noise_value !== noise_queue[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("noise mismatch: expected %0d got %0d",
                                 noise_queue[0], o_noise_value);
                end
                void'(noise_queue.pop_front());
            end
        end
    end

    task automatic idle_cycles(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic issue_item(t_row r);
        start <= 1'b1;
        i_kind <= r.kind;
        i_table_index <= r.idx;
        i_table_value <= r.val;
        i_coord_x <= r.x;
        i_coord_y <= r.y;
        do @(posedge i_clk); while (busy);
        if (r.kind == KIND_LOAD) begin
            perm_copy[r.idx] = r.val;
            loads_done++;
        end else begin
            noise_queue.push_back(fbm_noise(r.x, r.y));
            evals_done++;
        end
        if (allow_idle && $urandom_range(0, 3) == 0)
            idle_cycles($urandom_range(1, 13));
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        start <= 1'b0;
        wait (noise_queue.size() == 0);
        repeat (8) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_OCTAVES: octaves_reg = data[4:0];
            CFG_LACUN:   lacun_reg = data;
            CFG_GAIN:    gain_reg = data;
            default: ;
        endcase
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'sh7FFF_FFFF - $urandom_range(0, 3);
            2: return 32'sh8000_0000 + $urandom_range(0, 3);
            default: return $signed(32'($urandom_range(0, 32'h0020_0000))) - 32'sh0010_0000;
        endcase
    endfunction

    task automatic random_items(int count);
        t_row r;
        for (int i = 0; i < count; i++) begin
            r.kind = ($urandom_range(0, 4) == 0) ? KIND_LOAD : KIND_EVAL;
            r.idx = 8'($urandom);
            r.val = 8'($urandom);
            r.x = rand_coord();
            r.y = rand_coord();
            issue_item(r);
        end
    endtask

    t_row directed [14];
    logic [15:0] phase_oct [9] = '{16'd1, 16'd16, 16'd0, 16'hFFF1, 16'd2, 16'd17,
                                   16'd3, 16'd5, 16'd4};
    logic [15:0] phase_lac [9] = '{16'd0, 16'hFFFF, 16'd8192, 16'd4096, 16'hA5A5,
                                   16'd12288, 16'd1, 16'd6000, 16'd8192};
    logic [15:0] phase_gain [9] = '{16'hFFFF, 16'd0, 16'd32768, 16'h5A5A, 16'd1,
                                    16'd45000, 16'hFFFF, 16'd20000, 16'd32768};

    initial begin
        t_row r;
        directed = '{
            '{KIND_LOAD, 8'd0, 8'd255, 0, 0},
            '{KIND_LOAD, 8'd255, 8'd0, 0, 0},
            '{KIND_EVAL, 8'd0, 8'd0, 32'sd0, 32'sd0},
            '{KIND_EVAL, 8'd0, 8'd0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF},
            '{KIND_EVAL, 8'd0, 8'd0, 32'sh8000_0000, 32'sh8000_0000},
            '{KIND_EVAL, 8'd0, 8'd0, 32'sh7FFF_FFFF, 32'sh8000_0000},
            '{KIND_EVAL, 8'd0, 8'd0, 32'sh0001_0000, -32'sh0001_0000},
            '{KIND_EVAL, 8'd0, 8'd0, 32'sh0000_8000, 32'sh0000_4000},
            '{KIND_EVAL, 8'd0, 8'd0, 32'sh00FF_C000, 32'sh00FF_8000},
            '{KIND_EVAL, 8'd0, 8'd0, -32'sd1, -32'sd1},
            '{KIND_EVAL, 8'd0, 8'd0, 32'sh0000_4000, 32'sh0000_C000},
            '{KIND_LOAD, 8'd128, 8'd7, 0, 0},
            '{KIND_EVAL, 8'd0, 8'd0, 32'sh0080_0000, 32'sh007F_0000},
            '{KIND_EVAL, 8'd0, 8'd0, 32'sh5555_5555, 32'shAAAA_AAAA}
        };
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // every entry is written before any evaluate reads the table
        for (int i = 0; i < 256; i++) begin
            r = '{KIND_LOAD, 8'(i), 8'($urandom), 0, 0};
            issue_item(r);
        end
        foreach (directed[i]) issue_item(directed[i]);
        for (int p = 0; p < 9; p++) begin
            write_reg(CFG_OCTAVES, phase_oct[p]);
            write_reg(CFG_LACUN, phase_lac[p]);
            write_reg(CFG_GAIN, phase_gain[p]);
            if (p == 8) allow_idle = 1'b0;
            random_items((phase_oct[p][4:0] >= 16 || phase_oct[p][4:0] == 0) ? 15 : 40);
        end
        start <= 1'b0;
        wait (noise_queue.size() == 0);
        repeat (80) @(posedge i_clk);
        $display("covered %0d table loads and %0d noise evaluations over 9 settings",
                 loads_done, evals_done);
        if (mismatches == 0 && noise_queue.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #30ms;
        $display("Some tests failed");
        $finish;
    end

endmodule

### files.f
rtl/fsn_pkg.sv
rtl/fsn_ram.sv
rtl/fsn_ctrl.sv
rtl/fsn_dp.sv
rtl/fractal_simplex_noise_2d.sv
test/fractal_simplex_noise_2d_tb.sv
